@@ hdl/assert_macros.svh @@
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ hdl/iaee_pkg.sv @@
// ----------------------------------------------------------------------------
// iaee_pkg
// Shared types, character codes and decode helpers of the expression evaluator.
// ----------------------------------------------------------------------------
package iaee_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned OUT_WIDTH       = 32;
  localparam int unsigned CHAR_WIDTH      = 8;

  localparam logic [CHAR_WIDTH-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_WIDTH-1:0] CHAR_STAR  = 8'h2A;
  localparam logic [CHAR_WIDTH-1:0] CHAR_SLASH = 8'h2F;
  localparam logic [CHAR_WIDTH-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_WIDTH-1:0] CHAR_NINE  = 8'h39;

  typedef enum logic [2:0] {
    K_OTHER,
    K_DIGIT,
    K_ADD,
    K_SUB,
    K_MUL,
    K_DIV
  } char_kind_e;

  typedef enum logic [1:0] {
    ADD_NONE,
    ADD_PLUS,
    ADD_MINUS
  } add_op_e;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_TIMES,
    MUL_DIVIDE
  } mul_op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TERM,
    S_CALC,
    S_FOLD
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic       digit_en;
    logic       take_term;
    logic       fold_op;
    logic       emit;
    char_kind_e kind;
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic mul_pending;
    logic unit_done;
  } dp_status_t;

  function automatic char_kind_e classify(input logic [CHAR_WIDTH-1:0] c);
    char_kind_e k;
    priority if (c >= CHAR_ZERO && c <= CHAR_NINE) k = K_DIGIT;
    else if (c == CHAR_PLUS)  k = K_ADD;
    else if (c == CHAR_MINUS) k = K_SUB;
    else if (c == CHAR_STAR)  k = K_MUL;
    else if (c == CHAR_SLASH) k = K_DIV;
    else                      k = K_OTHER;  // space and anything else
    return k;
  endfunction

  function automatic logic is_operator(input char_kind_e k);
    return (k == K_ADD) || (k == K_SUB) || (k == K_MUL) || (k == K_DIV);
  endfunction

endpackage

@@ hdl/infix_arith_expression_evaluator_top.sv @@
// ----------------------------------------------------------------------------
// infix_arith_expression_evaluator_top
// Evaluates a + - * / expression without parentheses, one character a beat.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o carry one ASCII character per beat
// (char_code_i) and end_of_expr_i on the last one. Digits build the operand,
// operators fold it, spaces and other codes are skipped.
// Output channel: out_valid_o / out_stall_i carry one result per expression,
// value_o (low 32 bits, two's complement) and error_o (missing operand or
// division by zero; value_o is then 0).
// Steps: a digit or skipped character is taken in the idle state. An
// operator closes the operand, waits for the multiply/divide unit when a *
// or / is pending (it resolves one bit per cycle and skips the loop on a
// zero divisor), then folds. A last digit or skipped character goes through
// the same steps; a last operator closes one more (missing) operand.
// The result is then registered and shows on out_valid_o the cycle after.
// The result sits in an output register, so the next expression is accepted
// while it waits. If a second result is ready while the first is stalled,
// the block holds and stalls its input until the receiver takes the first.
// Reset returns the block to the start of an expression with no result
// pending.
// ----------------------------------------------------------------------------
module infix_arith_expression_evaluator_top import iaee_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [CHAR_WIDTH-1:0]       char_code_i,
  input  logic                        end_of_expr_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [OUT_WIDTH-1:0] value_o,
  output logic                        error_o
);

  ctrl_cmd_t            cmd;
  dp_status_t           status;
  logic [OUT_WIDTH-1:0] value_raw;

  iaee_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .char_code_i   (char_code_i),
    .end_of_expr_i (end_of_expr_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .cmd_o         (cmd),
    .status_i      (status)
  );

  iaee_datapath #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .char_code_i (char_code_i),
    .status_o    (status),
    .value_o     (value_raw),
    .error_o     (error_o)
  );

  assign value_o = $signed(value_raw);

endmodule

@@ hdl/iaee_muldiv.sv @@
// ----------------------------------------------------------------------------
// iaee_muldiv
// Shared iterative unit: shift-add multiply or restoring signed divide,
// one bit per cycle.
// ----------------------------------------------------------------------------
module iaee_muldiv import iaee_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic                   div_i,
  input  logic [VALUE_WIDTH-1:0] a_i,
  input  logic [VALUE_WIDTH-1:0] b_i,
  output logic                   done_o,
  output logic                   div_zero_o,
  output logic [VALUE_WIDTH-1:0] result_o
);

  localparam int unsigned CNT_W = $clog2(VALUE_WIDTH + 1);
  localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(VALUE_WIDTH);

  logic                   busy_q, busy_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   div_q, div_d;
  logic                   neg_q, neg_d;
  logic                   dz_q, dz_d;
  logic [VALUE_WIDTH-1:0] a_q, a_d;
  logic [VALUE_WIDTH-1:0] b_q, b_d;
  logic [VALUE_WIDTH-1:0] acc_q, acc_d;
  logic [VALUE_WIDTH:0]   trial;
  logic [VALUE_WIDTH:0]   trial_sub;
  logic [VALUE_WIDTH-1:0] a_mag, b_mag;

  assign a_mag     = a_i[VALUE_WIDTH-1] ? (~a_i + 1'b1) : a_i;
  assign b_mag     = b_i[VALUE_WIDTH-1] ? (~b_i + 1'b1) : b_i;
  assign trial     = {acc_q, a_q[VALUE_WIDTH-1]};
  assign trial_sub = trial - {1'b0, b_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    div_d  = div_q;
    neg_d  = neg_q;
    dz_d   = dz_q;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    if (start_i) begin
      busy_d = 1'b1;
      div_d  = div_i;
      acc_d  = '0;
      if (div_i) begin
        a_d   = a_mag;
        b_d   = b_mag;
        neg_d = a_i[VALUE_WIDTH-1] ^ b_i[VALUE_WIDTH-1];
        dz_d  = (b_i == '0);
        cnt_d = (b_i == '0) ? '0 : CNT_LOAD;
      end else begin
        a_d   = a_i;
        b_d   = b_i;
        neg_d = 1'b0;
        dz_d  = 1'b0;
        cnt_d = CNT_LOAD;
      end
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        cnt_d = cnt_q - 1'b1;
        if (div_q) begin
          // Restoring step: the quotient bit shifts into the dividend register.
          if (!trial_sub[VALUE_WIDTH]) begin
            acc_d = trial_sub[VALUE_WIDTH-1:0];
            a_d   = {a_q[VALUE_WIDTH-2:0], 1'b1};
          end else begin
            acc_d = trial[VALUE_WIDTH-1:0];
            a_d   = {a_q[VALUE_WIDTH-2:0], 1'b0};
          end
        end else begin
          acc_d = acc_q + (b_q[0] ? a_q : '0);
          a_d   = {a_q[VALUE_WIDTH-2:0], 1'b0};
          b_d   = {1'b0, b_q[VALUE_WIDTH-1:1]};
        end
      end else begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    neg_q <= neg_d;
    dz_q  <= dz_d;
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign done_o     = busy_q && (cnt_q == '0);
  assign div_zero_o = div_q && dz_q;

  always_comb begin
    if (!div_q)     result_o = acc_q;
    else if (dz_q)  result_o = '0;
    else if (neg_q) result_o = ~a_q + 1'b1;
    else            result_o = a_q;
  end

endmodule

@@ hdl/iaee_datapath.sv @@
// ----------------------------------------------------------------------------
// iaee_datapath
// Operand, pending sum and product registers, the fold adder and the result
// register; runs the shared multiply/divide unit on command.
// ----------------------------------------------------------------------------
module iaee_datapath import iaee_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ctrl_cmd_t             cmd_i,
  input  logic [CHAR_WIDTH-1:0] char_code_i,
  output dp_status_t            status_o,
  output logic [OUT_WIDTH-1:0]  value_o,
  output logic                  error_o
);

  logic [VALUE_WIDTH-1:0] acc_q, acc_d;
  logic                   seen_q, seen_d;
  logic [VALUE_WIDTH-1:0] sum_q, sum_d;
  add_op_e                add_op_q, add_op_d;
  logic [VALUE_WIDTH-1:0] prod_q, prod_d;
  mul_op_e                mul_op_q, mul_op_d;
  logic [VALUE_WIDTH-1:0] term_q, term_d;
  logic                   err_q, err_d;
  logic [OUT_WIDTH-1:0]   out_value_q, out_value_d;
  logic                   out_error_q, out_error_d;

  logic                   unit_start;
  logic                   unit_done;
  logic                   unit_dz;
  logic [VALUE_WIDTH-1:0] unit_res;
  logic [VALUE_WIDTH-1:0] opnd;
  logic [VALUE_WIDTH-1:0] fold_res;
  logic [VALUE_WIDTH-1:0] digit_next;
  logic [OUT_WIDTH-1:0]   res_out;

  assign opnd       = seen_q ? acc_q : '0;
  assign unit_start = cmd_i.take_term && (mul_op_q != MUL_NONE);
  assign digit_next = (acc_q << 3) + (acc_q << 1)
                    + VALUE_WIDTH'(char_code_i[3:0]);

  always_comb begin
    unique case (add_op_q)
      ADD_PLUS:  fold_res = sum_q + term_q;
      ADD_MINUS: fold_res = sum_q - term_q;
      default:   fold_res = term_q;
    endcase
  end

  if (VALUE_WIDTH >= OUT_WIDTH) begin : g_trunc
    assign res_out = fold_res[OUT_WIDTH-1:0];
  end else begin : g_ext
    assign res_out = {{(OUT_WIDTH - VALUE_WIDTH){1'b0}}, fold_res};
  end

  iaee_muldiv #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_muldiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (unit_start),
    .div_i      (mul_op_q == MUL_DIVIDE),
    .a_i        (prod_q),
    .b_i        (opnd),
    .done_o     (unit_done),
    .div_zero_o (unit_dz),
    .result_o   (unit_res)
  );

  always_comb begin
    acc_d       = acc_q;
    seen_d      = seen_q;
    sum_d       = sum_q;
    add_op_d    = add_op_q;
    prod_d      = prod_q;
    mul_op_d    = mul_op_q;
    term_d      = term_q;
    err_d       = err_q;
    out_value_d = out_value_q;
    out_error_d = out_error_q;

    if (cmd_i.digit_en) begin
      acc_d  = digit_next;
      seen_d = 1'b1;
    end

    // Close the current operand; a missing one counts as zero.
    if (cmd_i.take_term) begin
      term_d = opnd;
      err_d  = err_q | ~seen_q;
      acc_d  = '0;
      seen_d = 1'b0;
    end

    if (unit_done) begin
      term_d = unit_res;
      err_d  = err_q | unit_dz;
    end

    if (cmd_i.fold_op) begin
      unique case (cmd_i.kind)
        K_MUL: begin
          prod_d   = term_q;
          mul_op_d = MUL_TIMES;
        end
        K_DIV: begin
          prod_d   = term_q;
          mul_op_d = MUL_DIVIDE;
        end
        K_ADD: begin
          sum_d    = fold_res;
          add_op_d = ADD_PLUS;
          prod_d   = '0;
          mul_op_d = MUL_NONE;
        end
        K_SUB: begin
          sum_d    = fold_res;
          add_op_d = ADD_MINUS;
          prod_d   = '0;
          mul_op_d = MUL_NONE;
        end
        default: ;
      endcase
    end

    // Deliver the result and return to the start-of-expression state.
    if (cmd_i.emit) begin
      out_value_d = err_q ? '0 : res_out;
      out_error_d = err_q;
      acc_d       = '0;
      seen_d      = 1'b0;
      sum_d       = '0;
      add_op_d    = ADD_NONE;
      prod_d      = '0;
      mul_op_d    = MUL_NONE;
      err_d       = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      seen_q   <= 1'b0;
      sum_q    <= '0;
      add_op_q <= ADD_NONE;
      prod_q   <= '0;
      mul_op_q <= MUL_NONE;
      err_q    <= 1'b0;
    end else begin
      acc_q    <= acc_d;
      seen_q   <= seen_d;
      sum_q    <= sum_d;
      add_op_q <= add_op_d;
      prod_q   <= prod_d;
      mul_op_q <= mul_op_d;
      err_q    <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    term_q      <= term_d;
    out_value_q <= out_value_d;
    out_error_q <= out_error_d;
  end

  assign status_o.mul_pending = (mul_op_q != MUL_NONE);
  assign status_o.unit_done   = unit_done;
  assign value_o              = out_value_q;
  assign error_o              = out_error_q;

endmodule

@@ hdl/iaee_ctrl.sv @@
// ----------------------------------------------------------------------------
// iaee_ctrl
// Sequencer: takes a character beat, steps operand close, multiply/divide
// and fold, and owns the output valid.
// ----------------------------------------------------------------------------
module iaee_ctrl import iaee_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [CHAR_WIDTH-1:0] char_code_i,
  input  logic                  end_of_expr_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output ctrl_cmd_t             cmd_o,
  input  dp_status_t            status_i
);

  state_e     state_q, state_d;
  char_kind_e kind_q, kind_d;
  logic       last_q, last_d;
  logic       out_valid_q, out_valid_d;
  char_kind_e in_kind;
  logic       out_free;

  assign in_kind  = classify(char_code_i);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d         = state_q;
    kind_d          = kind_q;
    last_d          = last_q;
    cmd_o.digit_en  = 1'b0;
    cmd_o.take_term = 1'b0;
    cmd_o.fold_op   = 1'b0;
    cmd_o.emit      = 1'b0;
    cmd_o.kind      = kind_q;
    in_stall_o      = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.digit_en = (in_kind == K_DIGIT);
          if (is_operator(in_kind) || end_of_expr_i) begin
            kind_d  = is_operator(in_kind) ? in_kind : K_OTHER;
            last_d  = end_of_expr_i;
            state_d = S_TERM;
          end
        end
      end
      S_TERM: begin
        cmd_o.take_term = 1'b1;
        state_d = status_i.mul_pending ? S_CALC : S_FOLD;
      end
      S_CALC: begin
        if (status_i.unit_done) state_d = S_FOLD;
      end
      S_FOLD: begin
        if (is_operator(kind_q)) begin
          cmd_o.fold_op = 1'b1;
          kind_d        = K_OTHER;
          // An operator as the last character still closes a (missing) operand.
          state_d       = last_q ? S_TERM : S_IDLE;
        end else if (out_free) begin
          cmd_o.emit = 1'b1;
          last_d     = 1'b0;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    out_valid_d = cmd_o.emit | (out_valid_q & out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      kind_q      <= K_OTHER;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ hdl/iaee_checker.sv @@
// ----------------------------------------------------------------------------
// iaee_checker
// Port-level checks of the expression evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module iaee_checker import iaee_pkg::*; (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic [CHAR_WIDTH-1:0]       char_code_i,
  input logic                        end_of_expr_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic signed [OUT_WIDTH-1:0] value_o,
  input logic                        error_o
);

  `ASSERT_CLK(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "result dropped while stalled")
  `ASSERT_CLK(a_out_stable, out_valid_o && out_stall_i |=> $stable(value_o) && $stable(error_o), "stalled result changed")
  `ASSERT_CLK(a_err_zero, out_valid_o && error_o |-> value_o == '0, "error result with nonzero value")
  `ASSERT_CLK(a_last_busy, in_valid_i && !in_stall_o && end_of_expr_i |=> in_stall_o, "beat taken right after last character")
  `ASSERT_ALWAYS(a_rst_quiet, !rst_ni |=> !out_valid_o, "result valid after reset")

endmodule

bind infix_arith_expression_evaluator_top iaee_checker u_iaee_checker (.*);

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Checks the infix expression evaluator against an in-bench evaluator.
// Sends ASCII expressions one character a beat, computes the value and
// error flag of each one, and matches every result beat in order. Runs
// directed corner expressions, then random expressions under several
// patterns of sender gaps and receiver back-pressure.
// ----------------------------------------------------------------------------
module testbench import iaee_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned TAIL_CYCLES = 2 * (VALUE_WIDTH_DEF + 4) + 16;
  localparam int unsigned PHASE_CHARS = 450;

  typedef logic [CHAR_WIDTH-1:0] char_q_t[$];

  typedef struct {
    logic [OUT_WIDTH-1:0] value;
    logic                 flag;
  } answer_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  logic [CHAR_WIDTH-1:0]       char_code_i = '0;
  logic                        end_of_expr_i = 1'b0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic signed [OUT_WIDTH-1:0] value_o;
  logic                        error_o;

  // Evaluator state, mirrors what the block keeps between characters.
  logic [31:0] run_sum;
  logic [31:0] run_product;
  logic [31:0] operand;
  add_op_e     sum_op;
  mul_op_e     product_op;
  logic        operand_seen;
  logic        expr_failed;

  answer_t     pending_answers[$];
  answer_t     head;
  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned chars_sent = 0;
  int unsigned exprs_sent = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  infix_arith_expression_evaluator_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .char_code_i   (char_code_i),
    .end_of_expr_i (end_of_expr_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .value_o       (value_o),
    .error_o       (error_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_answers.size());
      $display("simulation failed");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // Evaluator
  // ------------------------------------------------------------------------
  function automatic logic [31:0] signed_quotient(input logic [31:0] a,
                                                  input logic [31:0] b);
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic [31:0] q;
    mag_a = a[31] ? -a : a;
    mag_b = b[31] ? -b : b;
    q = mag_a / mag_b;
    return (a[31] ^ b[31]) ? -q : q;
  endfunction

  // Close the current operand and fold it into the running product.
  function automatic logic [31:0] close_operand();
    logic [31:0] opnd;
    logic [31:0] term;
    opnd = operand;
    if (!operand_seen) begin
      expr_failed = 1'b1;
      opnd = '0;
    end
    operand = '0;
    operand_seen = 1'b0;
    case (product_op)
      MUL_TIMES: term = run_product * opnd;
      MUL_DIVIDE: begin
        if (opnd == '0) begin
          expr_failed = 1'b1;
          term = '0;
        end else begin
          term = signed_quotient(run_product, opnd);
        end
      end
      default: term = opnd;
    endcase
    return term;
  endfunction

  function automatic logic [31:0] fold_term(input logic [31:0] term);
    case (sum_op)
      ADD_PLUS:  return run_sum + term;
      ADD_MINUS: return run_sum - term;
      default:   return term;
    endcase
  endfunction

  function automatic void clear_evaluator();
    run_sum = '0;
    run_product = '0;
    operand = '0;
    sum_op = ADD_NONE;
    product_op = MUL_NONE;
    operand_seen = 1'b0;
    expr_failed = 1'b0;
  endfunction

  function automatic void eval_char(input logic [CHAR_WIDTH-1:0] c, input logic last);
    logic [31:0] total;
    answer_t     ans;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      operand = operand * 32'd10 + {24'd0, c - CHAR_ZERO};
      operand_seen = 1'b1;
    end else if (c == CHAR_STAR || c == CHAR_SLASH) begin
      run_product = close_operand();
      product_op = (c == CHAR_STAR) ? MUL_TIMES : MUL_DIVIDE;
    end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
      run_sum = fold_term(close_operand());
      sum_op = (c == CHAR_PLUS) ? ADD_PLUS : ADD_MINUS;
      product_op = MUL_NONE;
      run_product = '0;
    end
    if (last) begin
      total = fold_term(close_operand());
      ans.value = expr_failed ? '0 : total;
      ans.flag = expr_failed;
      pending_answers.push_back(ans);
      clear_evaluator();
    end
  endfunction

  // ------------------------------------------------------------------------
  // Result side
  // ------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_answers.size() == 0) begin
        report_mismatch($sformatf("unexpected result value=%0d error=%0b", value_o,
                                  error_o));
      end else begin
        head = pending_answers.pop_front();
        results_checked++;
        if (value_o !== head.value)
          report_mismatch($sformatf("result %0d value %0d, want %0d", results_checked,
                                    value_o, $signed(head.value)));
        if (error_o !== head.flag)
          report_mismatch($sformatf("result %0d error %0b, want %0b", results_checked,
                                    error_o, head.flag));
      end
    end
  end

  // ------------------------------------------------------------------------
  // Input side
  // ------------------------------------------------------------------------
  task automatic send_char(input logic [CHAR_WIDTH-1:0] c, input logic last);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    char_code_i <= c;
    end_of_expr_i <= last;
    // hold the beat until it is taken
    do @(posedge clk_i); while (in_stall_o);
    eval_char(c, last);
    chars_sent++;
  endtask

  task automatic send_chars(input char_q_t q);
    foreach (q[i]) send_char(q[i], i == q.size() - 1);
    exprs_sent++;
  endtask

  task automatic send_text(input string s);
    char_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    send_chars(q);
  endtask

  task automatic wait_drained();
    while (pending_answers.size() != 0) @(posedge clk_i);
  endtask

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------
  task automatic test_precedence();
    // all four operators, * and / left to right inside a - chain
    send_text("8-3*5/2-1+6");
    send_text("7");
  endtask

  task automatic test_error_cases();
    send_text("5/0");
    // missing first operand, end right after an operator
    send_text("+4*");
    // empty expression
    send_text(" ");
  endtask

  task automatic test_wrap_cases();
    // most negative divided by -1 wraps back to most negative
    send_text("2147483648/4294967295");
  endtask

  task automatic test_ignored_chars();
    char_q_t q;
    q = '{CHAR_ZERO + 8'd7, 8'hFF, 8'h00, CHAR_SPACE};
    send_chars(q);
  endtask

  task automatic test_random_expressions(input int unsigned gap_pct,
                                         input int unsigned stall_pct);
    char_q_t              q;
    int unsigned          target;
    int unsigned          n_terms;
    int unsigned          n_digits;
    int unsigned          r;
    logic [CHAR_WIDTH-1:0] junk;
    logic [CHAR_WIDTH-1:0] ops[4];
    ops = '{CHAR_PLUS, CHAR_MINUS, CHAR_STAR, CHAR_SLASH};
    send_gap_pct = gap_pct;
    recv_stall_pct = stall_pct;
    target = chars_sent + PHASE_CHARS;
    while (chars_sent < target) begin
      q.delete();
      if ($urandom_range(99) < 6) begin
        // raw noise over the whole byte range
        repeat ($urandom_range(1, 12)) q.push_back(CHAR_WIDTH'($urandom_range(0, 255)));
      end else begin
        n_terms = $urandom_range(1, 6);
        for (int t = 0; t < n_terms; t++) begin
          if (t != 0) q.push_back(ops[$urandom_range(3)]);
          if ($urandom_range(9) < 2) q.push_back(CHAR_SPACE);
          r = $urandom_range(99);
          if (r < 3) n_digits = 0;
          else if (r < 70) n_digits = $urandom_range(1, 2);
          else if (r < 92) n_digits = $urandom_range(3, 5);
          else n_digits = $urandom_range(6, 12);
          repeat (n_digits) q.push_back(CHAR_ZERO + CHAR_WIDTH'($urandom_range(0, 9)));
          if ($urandom_range(19) == 0) begin
            junk = CHAR_WIDTH'($urandom_range(0, 255));
            if ((junk >= CHAR_ZERO && junk <= CHAR_NINE) || junk == CHAR_PLUS ||
                junk == CHAR_MINUS || junk == CHAR_STAR || junk == CHAR_SLASH)
              junk = CHAR_SPACE;
            q.push_back(junk);
          end
          if ($urandom_range(9) < 2) q.push_back(CHAR_SPACE);
        end
        r = $urandom_range(19);
        if (r == 0) q.push_back(ops[$urandom_range(3)]);
        else if (r == 1) q.push_back(CHAR_SPACE);
      end
      send_chars(q);
    end
    in_valid_i <= 1'b0;
    wait_drained();
  endtask

  initial begin
    clear_evaluator();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_precedence();
    test_error_cases();
    test_wrap_cases();
    test_ignored_chars();
    in_valid_i <= 1'b0;
    wait_drained();

    test_random_expressions(0, 0);
    test_random_expressions(50, 0);
    test_random_expressions(0, 50);
    test_random_expressions(18, 18);

    recv_stall_pct = 0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("sent %0d characters in %0d expressions, checked %0d results",
             chars_sent, exprs_sent, results_checked);
    $display("phases: free flow, sender gaps, receiver stalls, both mixed");
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/iaee_pkg.sv
hdl/iaee_muldiv.sv
hdl/iaee_datapath.sv
hdl/iaee_ctrl.sv
hdl/infix_arith_expression_evaluator_top.sv
hdl/iaee_checker.sv
dv/testbench.sv
